[design/c8_pkg.sv]
// ----------------------------------------------------------------------------
// c8_pkg: shared types and constants
// Field widths, command and status codes, and the memory request type.
// ----------------------------------------------------------------------------
package c8_pkg;

  localparam int MEM_BYTES     = 4096;
  localparam int STACK_DEPTH   = 16;
  localparam int SCREEN_WIDTH  = 64;
  localparam int SCREEN_HEIGHT = 32;

  localparam int AW  = 12;
  localparam int RW  = 5;
  localparam int SPW = 5;
  localparam int SIW = 4;

  localparam logic [AW-1:0] PC_RESET = 12'h200;

  localparam logic [2:0] CMD_LOAD  = 3'd0;
  localparam logic [2:0] CMD_EXEC  = 3'd1;
  localparam logic [2:0] CMD_TICK  = 3'd2;
  localparam logic [2:0] CMD_ROW   = 3'd3;
  localparam logic [2:0] CMD_READ  = 3'd4;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_UNK   = 2'd1;
  localparam logic [1:0] ST_WAIT  = 2'd2;
  localparam logic [1:0] ST_STACK = 2'd3;

  // Bundle handed from the sequencer to the RAM wrapper
  typedef struct packed {
    logic          we;
    logic [AW-1:0] addr;
    logic [7:0]    wdata;
  } mem_req_t;

endpackage

[design/c8_ram.sv]
// ----------------------------------------------------------------------------
// c8_ram: generic single-port RAM
// One write or read per cycle, read data registered.
// ----------------------------------------------------------------------------
module c8_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

[design/c8_alu.sv]
// ----------------------------------------------------------------------------
// c8_alu: shared 8-bit ALU
// Handles the 8XYn group, add-immediate and the compare for skips.
// ----------------------------------------------------------------------------
module c8_alu
  import c8_pkg::*;
(
  input  logic [3:0] op,
  input  logic [7:0] a,
  input  logic [7:0] b,
  output logic [7:0] res,
  output logic       flag,
  output logic       eq
);

  logic [8:0] sum;
  logic [8:0] dab;
  logic [8:0] dba;

  assign sum = {1'b0, a} + {1'b0, b};
  assign dab = {1'b0, a} - {1'b0, b};
  assign dba = {1'b0, b} - {1'b0, a};
  assign eq  = (a == b);

  always_comb begin
    res  = b;
    flag = 1'b0;
    unique case (op)
      4'h0: res = b;
      4'h1: res = a | b;
      4'h2: res = a & b;
      4'h3: res = a ^ b;
      4'h4: begin res = sum[7:0]; flag = sum[8]; end
      4'h5: begin res = dab[7:0]; flag = ~dab[8]; end
      4'h6: begin res = {1'b0, a[7:1]}; flag = a[0]; end
      4'h7: begin res = dba[7:0]; flag = ~dba[8]; end
      4'hE: begin res = {a[6:0], 1'b0}; flag = a[7]; end
      default: begin res = sum[7:0]; flag = sum[8]; end
    endcase
  end

endmodule

[design/chip8_instruction_core.sv]
// ----------------------------------------------------------------------------
// chip8_instruction_core: CHIP-8 interpreter core
// Memory in a single-port RAM, registers, stack and frame buffer in flops,
// instructions run by a small sequencer around one shared ALU.
// ----------------------------------------------------------------------------
//  channel | direction | handshake
//  in_*    | in        | in_valid / in_stall
//  out_*   | out       | out_valid / out_stall
//  cfg_*   | in        | cfg_we, no wait
//
// Load, row and tick pass through S_F2 and read through S_RD before the result.
// Execute fetches the opcode over the single RAM port in S_F0 and S_F1, then
// decodes in S_EXE; DXYN then walks its rows in S_DRAW.
// 00E0 clears all rows at once.
// Reset is synchronous; the RAM has no reset and is cleared by a pass over
// all 4096 addresses after reset, during which no item is accepted.
// The result sits in an output register; the next item waits for it to go.
module chip8_instruction_core
  import c8_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  logic [2:0]    in_command,
  input  logic [AW-1:0] in_address,
  input  logic [7:0]    in_data,
  input  logic [15:0]   in_keys,
  input  logic [7:0]    in_random_byte,
  output logic          out_valid,
  input  logic          out_stall,
  output logic [AW-1:0] out_program_counter,
  output logic [7:0]    out_read_byte,
  output logic [63:0]   out_display_row,
  output logic          out_draw_flag,
  output logic          out_sound_on,
  output logic [1:0]    out_status,
  input  logic          cfg_we,
  input  logic [AW-1:0] cfg_program_start
);

  typedef enum logic [7:0] {
    S_CLR  = 8'b00000001,
    S_IDLE = 8'b00000010,
    S_F0   = 8'b00000100,
    S_F1   = 8'b00001000,
    S_F2   = 8'b00010000,
    S_EXE  = 8'b00100000,
    S_DRAW = 8'b01000000,
    S_RD   = 8'b10000000
  } state_t;

  state_t state_r, state_nxt;

  logic [AW-1:0] clr_r;
  logic [2:0]    cmd_r;
  logic [AW-1:0] addr_r;
  logic [15:0]   keys_r;
  logic [7:0]    rnd_r;
  logic [7:0]    v_r [16];
  logic [AW-1:0] i_r;
  logic [AW-1:0] pc_r;
  logic [AW-1:0] stk_r [STACK_DEPTH];
  logic [SPW-1:0] sp_r;
  logic [63:0]   fb_r [SCREEN_HEIGHT];
  logic [7:0]    dt_r, st_r;
  logic [15:0]   op_r;
  logic [3:0]    row_r;
  logic [5:0]    xs_r;
  logic [RW-1:0] ys_r;
  logic          hit_r;

  logic          ovalid_r;
  logic [AW-1:0] opc_r;
  logic [7:0]    orb_r;
  logic [63:0]   orow_r;
  logic          odraw_r, osnd_r;
  logic [1:0]    ost_r;

  mem_req_t      mreq;
  logic [7:0]    mrd;

  logic          acc;
  assign in_stall = (state_r != S_IDLE) || ovalid_r;
  assign acc = in_valid && !in_stall;

  // Memory port
  c8_ram #(.WIDTH(8), .DEPTH(MEM_BYTES)) u_ram (
    .clk(clk), .we(mreq.we), .addr(mreq.addr), .wdata(mreq.wdata), .rdata(mrd)
  );

  // Sprite rows are read in the cycle before their row is drawn
  always_comb begin
    mreq.we    = 1'b0;
    mreq.addr  = in_address;
    mreq.wdata = in_data;
    unique case (state_r)
      S_CLR: begin mreq.we = 1'b1; mreq.addr = clr_r; mreq.wdata = 8'd0; end
      S_IDLE: begin
        mreq.we = acc && (in_command == CMD_LOAD);
        mreq.addr = (in_command == CMD_EXEC) ? pc_r : in_address;
      end
      S_F0: mreq.addr = pc_r + AW'(1);
      S_EXE: mreq.addr = i_r;
      S_DRAW: mreq.addr = i_r + AW'(row_r) + AW'(1);
      default: mreq.addr = addr_r;
    endcase
  end

  // Decode fields
  logic [3:0] ox, oy, on;
  logic [7:0] onn;
  logic [AW-1:0] onnn, npc, skp;
  logic [7:0] vx, vy;
  assign ox = op_r[11:8];
  assign oy = op_r[7:4];
  assign on = op_r[3:0];
  assign onn = op_r[7:0];
  assign onnn = op_r[11:0];
  assign npc = pc_r + AW'(2);
  assign skp = pc_r + AW'(4);
  assign vx = v_r[ox];
  assign vy = v_r[oy];

  // Shared ALU
  logic [3:0] aop;
  logic [7:0] ab, ares;
  logic aflag, aeq;
  always_comb begin
    aop = on;
    ab  = vy;
    priority case (op_r[15:12])
      4'h3, 4'h4: begin aop = 4'h0; ab = onn; end
      4'h7: begin aop = 4'h4; ab = onn; end
      default: begin aop = on; ab = vy; end
    endcase
  end
  c8_alu u_alu (.op(aop), .a(vx), .b(ab), .res(ares), .flag(aflag), .eq(aeq));

  // Lowest pressed key
  logic [3:0] lowk;
  always_comb begin
    lowk = 4'd0;
    for (int k = 15; k >= 0; k--) begin
      if (keys_r[k]) lowk = 4'(k);
    end
  end

  // Sprite row rotated into place
  logic [63:0] spr;
  logic [127:0] dbl;
  assign dbl = {mrd, 56'd0, mrd, 56'd0} >> xs_r;
  assign spr = dbl[63:0];
  logic [RW-1:0] drow;
  assign drow = ys_r + RW'(row_r);

  logic fin;
  logic [1:0] fst;
  logic [1:0] frst;
  logic fdraw;
  logic [7:0] frb;
  logic [63:0] frow;

  // Program counter after the instruction in op_r
  logic [AW-1:0] xpc;
  always_comb begin
    xpc = npc;
    if (fst != ST_OK) xpc = pc_r;
    else begin
      unique case (op_r[15:12])
        4'h0: if (op_r[7:0] != 8'hE0) xpc = stk_r[SIW'(sp_r - SPW'(1))] + AW'(2);
        4'h1, 4'h2: xpc = onnn;
        4'h3, 4'h5: if (aeq) xpc = skp;
        4'h4, 4'h9: if (!aeq) xpc = skp;
        4'hB: xpc = onnn + AW'(v_r[0]);
        4'hE: if (keys_r[vx[3:0]] == (onn == 8'h9E)) xpc = skp;
        default: xpc = npc;
      endcase
    end
  end

  // Sound state as it stands after this edge
  logic fsnd;
  assign fsnd = (state_r == S_EXE && fst == ST_OK && op_r[15:12] == 4'hF &&
                 onn == 8'h18) ? (vx != 8'd0) : (st_r != 8'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_CLR;
      clr_r    <= '0;
      ovalid_r <= 1'b0;
      pc_r     <= PC_RESET;
      i_r      <= '0;
      sp_r     <= '0;
      dt_r     <= '0;
      st_r     <= '0;
      for (int j = 0; j < 16; j++) v_r[j] <= '0;
      for (int j = 0; j < STACK_DEPTH; j++) stk_r[j] <= '0;
      for (int j = 0; j < SCREEN_HEIGHT; j++) fb_r[j] <= '0;
    end else begin
      state_r <= state_nxt;
      if (out_valid && !out_stall) ovalid_r <= 1'b0;
      if (cfg_we) pc_r <= cfg_program_start;
      if (state_r == S_CLR) clr_r <= clr_r + AW'(1);
      if (acc) begin
        cmd_r <= in_command; addr_r <= in_address;
        keys_r <= in_keys; rnd_r <= in_random_byte;
        if (in_command == CMD_TICK) begin
          if (dt_r != 0) dt_r <= dt_r - 8'd1;
          if (st_r != 0) st_r <= st_r - 8'd1;
        end
      end
      if (state_r == S_F0) op_r[15:8] <= mrd;
      if (state_r == S_F1) op_r[7:0] <= mrd;
      if (state_r == S_EXE) begin
        row_r <= 4'd0; hit_r <= 1'b0;
        xs_r <= vx[5:0]; ys_r <= vy[RW-1:0];
        if (fst == ST_OK) begin
          pc_r <= xpc;
          priority case (op_r[15:12])
            4'h0: if (op_r[7:0] == 8'hE0) begin
              for (int j = 0; j < SCREEN_HEIGHT; j++) fb_r[j] <= '0;
            end else begin
              sp_r <= sp_r - SPW'(1);
            end
            4'h2: begin
              stk_r[SIW'(sp_r)] <= pc_r; sp_r <= sp_r + SPW'(1);
            end
            4'h6: v_r[ox] <= onn;
            4'h7: v_r[ox] <= ares;
            4'h8: begin
              // flag goes to VF after the result
              if (on == 4'h4 || on == 4'h5 || on == 4'h6 || on == 4'h7 || on == 4'hE)
              begin
                v_r[15] <= {7'd0, aflag};
                if (ox != 4'hF) v_r[ox] <= ares;
              end else begin
                v_r[ox] <= ares;
              end
            end
            4'hA: i_r <= onnn;
            4'hC: v_r[ox] <= rnd_r & onn;
            4'hF: priority case (onn)
              8'h07: v_r[ox] <= dt_r;
              8'h0A: v_r[ox] <= {4'd0, lowk};
              8'h15: dt_r <= vx;
              8'h18: st_r <= vx;
              default: i_r <= i_r + AW'(vx);
            endcase
            default: ;
          endcase
        end
      end
      if (state_r == S_DRAW) begin
        if (row_r != on) begin
          if ((fb_r[drow] & spr) != 0) hit_r <= 1'b1;
          fb_r[drow] <= fb_r[drow] ^ spr;
          row_r <= row_r + 4'd1;
        end else begin
          v_r[15] <= {7'd0, hit_r};
        end
      end
      if (fin) begin
        ovalid_r <= 1'b1;
        opc_r <= (state_r == S_EXE) ? xpc : pc_r;
        orb_r <= frb; orow_r <= frow; odraw_r <= fdraw; ost_r <= frst;
        osnd_r <= fsnd;
      end
    end
  end

  // Status of the instruction in op_r
  always_comb begin
    fst = ST_OK;
    priority case (op_r[15:12])
      4'h0: if (op_r == 16'h00EE) begin
        if (sp_r == 0) fst = ST_STACK;
      end else if (op_r != 16'h00E0) fst = ST_UNK;
      4'h2: if (sp_r >= SPW'(STACK_DEPTH)) fst = ST_STACK;
      4'h8: if (!(on <= 4'h7 || on == 4'hE)) fst = ST_UNK;
      4'hE: if (onn != 8'h9E && onn != 8'hA1) fst = ST_UNK;
      4'hF: begin
        if (onn == 8'h0A) begin
          if (keys_r == 0) fst = ST_WAIT;
        end else if (onn != 8'h07 && onn != 8'h15 && onn != 8'h18 && onn != 8'h1E)
          fst = ST_UNK;
      end
      default: fst = ST_OK;
    endcase
  end

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    fin = 1'b0; fdraw = 1'b0; frb = 8'd0; frow = '0; frst = ST_OK;
    unique case (state_r)
      S_CLR:  if (clr_r == AW'(MEM_BYTES - 1)) state_nxt = S_IDLE;
      S_IDLE: if (acc) begin
        priority case (in_command)
          CMD_EXEC: state_nxt = S_F0;
          CMD_READ: state_nxt = S_RD;
          default:  state_nxt = S_F2;
        endcase
      end
      S_RD: begin fin = 1'b1; frb = mrd; state_nxt = S_IDLE; end
      S_F2: begin
        fin = 1'b1;
        if (cmd_r == CMD_ROW) frow = fb_r[addr_r[RW-1:0]];
        state_nxt = S_IDLE;
      end
      S_F0: state_nxt = S_F1;
      S_F1: state_nxt = S_EXE;
      S_EXE: begin
        if (fst == ST_OK && op_r[15:12] == 4'hD) state_nxt = S_DRAW;
        else begin
          fin = 1'b1;
          frst = fst;
          fdraw = (fst == ST_OK) && (op_r == 16'h00E0);
          state_nxt = S_IDLE;
        end
      end
      S_DRAW: if (row_r == on) begin
        fin = 1'b1; fdraw = 1'b1; state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Result fields
  assign out_valid = ovalid_r;
  assign out_read_byte = orb_r;
  assign out_display_row = orow_r;
  assign out_draw_flag = odraw_r;
  assign out_status = ost_r;
  assign out_sound_on = osnd_r;
  assign out_program_counter = opc_r;

endmodule
